// ===== design/lrt_pkg.sv =====
package lrt_pkg;

    localparam int ROUTE_SLOTS_DEF = 64;
    localparam int INTF_COUNT_DEF  = 16;

    localparam logic [31:0] ADDR_ALL_ONES = 32'hFFFF_FFFF;
    localparam logic [5:0]  ADDR_BITS     = 6'd32;

    localparam logic [2:0] ACT_LOOKUP    = 3'd0;
    localparam logic [2:0] ACT_ADD       = 3'd1;
    localparam logic [2:0] ACT_REMOVE    = 3'd2;
    localparam logic [2:0] ACT_SET_STATE = 3'd3;
    localparam logic [2:0] ACT_DROP      = 3'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [2:0]  action;
        logic [31:0] addr;
        logic [5:0]  length;
        logic [3:0]  intf_index;
        logic        intf_state;
    } req_t;

    typedef struct packed {
        logic        hit;
        logic [31:0] match_prefix;
        logic [5:0]  match_length;
        logic [3:0]  match_intf;
        logic        status;
    } rsp_t;

    typedef struct packed {
        logic [31:0] prefix;
        logic [5:0]  length;
        logic [3:0]  intf;
    } route_t;

    localparam int ROUTE_W = $bits(route_t);

endpackage

// ===== design/lrt_ram.sv =====
module lrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== design/lpm_route_table_unit.sv =====
// Channel   Signals                      Direction  Contents
// req       req_valid, req_ready, req    in         one action beat (lrt_pkg req_t)
// rsp       rsp_valid, rsp_ready, rsp    out        one result beat (lrt_pkg rsp_t)
//
// Add, set state and unknown actions go from accept straight to the finish state,
// which loads the output register once it is free. Lookup, remove and drop walk
// the route memory one slot a cycle through its single read port before they finish.
// Reset clears the route count and marks every interface down; no clearing pass.
// A new beat is taken while a finished result waits in the output register.
module lpm_route_table_unit #(
    parameter int ROUTE_SLOTS = lrt_pkg::ROUTE_SLOTS_DEF,
    parameter int INTF_COUNT  = lrt_pkg::INTF_COUNT_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  lrt_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output lrt_pkg::rsp_t rsp
);

    localparam int AddrW = $clog2(ROUTE_SLOTS);
    localparam int CntW  = $clog2(ROUTE_SLOTS + 1);
    localparam int IntfW = $clog2(INTF_COUNT);

    lrt_pkg::state_t state_reg, state_next;
    lrt_pkg::req_t   op_reg, op_next;
    lrt_pkg::route_t best_reg, best_next;
    lrt_pkg::rsp_t   rsp_reg, rsp_next;

    logic [CntW-1:0]       cnt_reg, cnt_next;
    logic [CntW-1:0]       rd_reg, rd_next;
    logic [CntW-1:0]       wr_reg, wr_next;
    logic                  pend_reg, pend_next;
    logic                  found_reg, found_next;
    logic                  status_reg, status_next;
    logic                  rsp_valid_reg, rsp_valid_next;
    logic [INTF_COUNT-1:0] flags_reg, flags_next;

    logic                  ram_we;
    logic [AddrW-1:0]      ram_waddr;
    logic [AddrW-1:0]      ram_raddr;
    logic [lrt_pkg::ROUTE_W-1:0] ram_wdata;
    logic [lrt_pkg::ROUTE_W-1:0] ram_rdata;

    lrt_pkg::route_t entry;
    logic [31:0]     entry_mask;
    logic            entry_up;
    logic            entry_match;
    logic            entry_take;
    logic            entry_drop;
    logic            req_intf_ok;
    lrt_pkg::route_t add_route;

    lrt_ram #(
        .WIDTH(lrt_pkg::ROUTE_W),
        .DEPTH(ROUTE_SLOTS)
    ) u_route_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign req_ready = (state_reg == lrt_pkg::ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        entry = lrt_pkg::route_t'(ram_rdata);
        if (entry.length == 6'd0)
        begin
            entry_mask = 32'd0;
        end
        else if (entry.length > lrt_pkg::ADDR_BITS)
        begin
            entry_mask = lrt_pkg::ADDR_ALL_ONES;
        end
        else
        begin
            entry_mask = lrt_pkg::ADDR_ALL_ONES << (lrt_pkg::ADDR_BITS - entry.length);
        end
        entry_up    = (32'(entry.intf) < 32'(INTF_COUNT)) && flags_reg[IntfW'(entry.intf)];
        entry_match = ((op_reg.addr ^ entry.prefix) & entry_mask) == 32'd0;
        entry_take  = entry_up && entry_match
                      && (!found_reg || (entry.length > best_reg.length));
        if (op_reg.action == lrt_pkg::ACT_DROP)
        begin
            entry_drop = (entry.intf == op_reg.intf_index);
        end
        else
        begin
            entry_drop = (entry.prefix == op_reg.addr) && (entry.length == op_reg.length);
        end
    end

    always_comb
    begin
        req_intf_ok      = 32'(req.intf_index) < 32'(INTF_COUNT);
        add_route.prefix = req.addr;
        add_route.length = req.length;
        add_route.intf   = req.intf_index;
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        best_next      = best_reg;
        rsp_next       = rsp_reg;
        cnt_next       = cnt_reg;
        rd_next        = rd_reg;
        wr_next        = wr_reg;
        pend_next      = 1'b0;
        found_next     = found_reg;
        status_next    = status_reg;
        flags_next     = flags_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        ram_we         = 1'b0;
        ram_waddr      = cnt_reg[AddrW-1:0];
        ram_wdata      = add_route;
        ram_raddr      = rd_reg[AddrW-1:0];

        unique case (state_reg)
            lrt_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    op_next     = req;
                    best_next   = '0;
                    found_next  = 1'b0;
                    status_next = 1'b0;
                    rd_next     = '0;
                    wr_next     = '0;
                    state_next  = lrt_pkg::ST_FINISH;
                    unique case (req.action)
                        lrt_pkg::ACT_LOOKUP, lrt_pkg::ACT_REMOVE:
                        begin
                            state_next = lrt_pkg::ST_SCAN;
                        end
                        lrt_pkg::ACT_ADD:
                        begin
                            if (cnt_reg >= CntW'(ROUTE_SLOTS))
                            begin
                                status_next = 1'b1;
                            end
                            else
                            begin
                                ram_we   = 1'b1;
                                cnt_next = cnt_reg + 1'b1;
                            end
                        end
                        lrt_pkg::ACT_SET_STATE:
                        begin
                            if (req_intf_ok)
                            begin
                                flags_next[IntfW'(req.intf_index)] = req.intf_state;
                            end
                        end
                        lrt_pkg::ACT_DROP:
                        begin
                            if (req_intf_ok)
                            begin
                                flags_next[IntfW'(req.intf_index)] = 1'b0;
                            end
                            state_next = lrt_pkg::ST_SCAN;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            lrt_pkg::ST_SCAN:
            begin
                if (rd_reg < cnt_reg)
                begin
                    rd_next   = rd_reg + 1'b1;
                    pend_next = 1'b1;
                end
                if (pend_reg)
                begin
                    if (op_reg.action == lrt_pkg::ACT_LOOKUP)
                    begin
                        if (entry_take)
                        begin
                            best_next  = entry;
                            found_next = 1'b1;
                        end
                    end
                    else if (!entry_drop)
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = wr_reg[AddrW-1:0];
                        ram_wdata = entry;
                        wr_next   = wr_reg + 1'b1;
                    end
                end
                else if (rd_reg >= cnt_reg)
                begin
                    if (op_reg.action != lrt_pkg::ACT_LOOKUP)
                    begin
                        cnt_next = wr_reg;
                    end
                    state_next = lrt_pkg::ST_FINISH;
                end
            end

            lrt_pkg::ST_FINISH:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next.hit          = found_reg;
                    rsp_next.match_prefix = best_reg.prefix;
                    rsp_next.match_length = best_reg.length;
                    rsp_next.match_intf   = best_reg.intf;
                    rsp_next.status       = status_reg;
                    rsp_valid_next        = 1'b1;
                    state_next            = lrt_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = lrt_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lrt_pkg::ST_IDLE;
            cnt_reg       <= '0;
            rd_reg        <= '0;
            wr_reg        <= '0;
            pend_reg      <= 1'b0;
            found_reg     <= 1'b0;
            status_reg    <= 1'b0;
            rsp_valid_reg <= 1'b0;
            flags_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            rd_reg        <= rd_next;
            wr_reg        <= wr_next;
            pend_reg      <= pend_next;
            found_reg     <= found_next;
            status_reg    <= status_next;
            rsp_valid_reg <= rsp_valid_next;
            flags_reg     <= flags_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        best_reg <= best_next;
        rsp_reg  <= rsp_next;
    end

endmodule

// ===== sim/lpm_route_table_checker.sv =====
module lpm_route_table_checker
    import lrt_pkg::*;
#(
    parameter int ROUTE_SLOTS = ROUTE_SLOTS_DEF,
    parameter int INTF_COUNT  = INTF_COUNT_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    input  logic req_ready,
    input  req_t req,
    input  logic rsp_valid,
    input  logic rsp_ready,
    input  rsp_t rsp,
    output int   mismatch_count,
    output int   pending_count
);

    route_t route_mem [ROUTE_SLOTS];
    int     route_total = 0;
    bit     intf_up [INTF_COUNT];
    rsp_t   expected_rsp [$];
    int     fails = 0;

    initial
    begin
        foreach (intf_up[i])
        begin
            intf_up[i] = 1'b0;
        end
    end

    // Applies one action beat to the shadow table and returns its result beat.
    function automatic rsp_t apply_action(req_t r);
        rsp_t        o;
        int          best;
        int          eff;
        int          kept;
        bit          drop;
        logic [31:0] m;
        o = '0;
        best = -1;
        case (r.action)
            ACT_LOOKUP:
            begin
                for (int i = 0; i < route_total; i++)
                begin
                    if (route_mem[i].intf < INTF_COUNT && intf_up[route_mem[i].intf])
                    begin
                        eff = (route_mem[i].length > ADDR_BITS) ? ADDR_BITS : route_mem[i].length;
                        m = ADDR_ALL_ONES << (ADDR_BITS - eff);
                        if ((r.addr & m) == (route_mem[i].prefix & m) &&
                            (best < 0 || route_mem[i].length > route_mem[best].length))
                        begin
                            best = i;
                        end
                    end
                end
                if (best >= 0)
                begin
                    o.hit = 1'b1;
                    o.match_prefix = route_mem[best].prefix;
                    o.match_length = route_mem[best].length;
                    o.match_intf = route_mem[best].intf;
                end
            end
            ACT_ADD:
            begin
                if (route_total >= ROUTE_SLOTS)
                begin
                    o.status = 1'b1;
                end
                else
                begin
                    route_mem[route_total] = '{prefix: r.addr, length: r.length,
                                               intf: r.intf_index};
                    route_total++;
                end
            end
            ACT_SET_STATE:
            begin
                if (r.intf_index < INTF_COUNT)
                begin
                    intf_up[r.intf_index] = r.intf_state;
                end
            end
            ACT_REMOVE, ACT_DROP:
            begin
                if (r.action == ACT_DROP && r.intf_index < INTF_COUNT)
                begin
                    intf_up[r.intf_index] = 1'b0;
                end
                kept = 0;
                for (int i = 0; i < route_total; i++)
                begin
                    if (r.action == ACT_DROP)
                    begin
                        drop = (route_mem[i].intf == r.intf_index);
                    end
                    else
                    begin
                        drop = (route_mem[i].prefix == r.addr &&
                                route_mem[i].length == r.length);
                    end
                    if (!drop)
                    begin
                        route_mem[kept] = route_mem[i];
                        kept++;
                    end
                end
                route_total = kept;
            end
            default:
            begin
            end
        endcase
        return o;
    endfunction

    task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            fails++;
        end
    endtask

    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (expected_rsp.size() == 0)
                begin
                    $display("%0t: result beat with none expected, actual %h", $time, rsp);
                    fails++;
                end
                else
                begin
                    want = expected_rsp.pop_front();
                    check_field("hit", 32'(want.hit), 32'(rsp.hit));
                    check_field("match_prefix", want.match_prefix, rsp.match_prefix);
                    check_field("match_length", 32'(want.match_length),
                                32'(rsp.match_length));
                    check_field("match_intf", 32'(want.match_intf), 32'(rsp.match_intf));
                    check_field("status", 32'(want.status), 32'(rsp.status));
                end
            end
            if (req_valid && req_ready)
            begin
                expected_rsp.insert(expected_rsp.size(), apply_action(req));
            end
        end
        mismatch_count <= fails;
        pending_count <= expected_rsp.size();
    end

endmodule

// ===== sim/tb_lpm_route_table_unit.sv =====
module tb_lpm_route_table_unit;
    import lrt_pkg::*;

    localparam int HOLD_CYCLES = 400;
    localparam int STALL_LIMIT = 3000;
    localparam int DRAIN_CYCLES = 80;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    req_t req = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp;

    int   mismatch_count;
    int   pending_count;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    logic hold_req = 1'b0;
    bit   hold_done = 1'b0;
    int   quiet_cycles = 0;
    req_t known_routes [$];

    lpm_route_table_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    lpm_route_table_checker u_route_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_ready      (req_ready),
        .req            (req),
        .rsp_valid      (rsp_valid),
        .rsp_ready      (rsp_ready),
        .rsp            (rsp),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // The receiver; the long hold-off lets the block fill up and stall its input.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                rsp_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end
            rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic send_beat(req_t r);
        int gap;
        req <= r;
        req_valid <= 1'b1;
        @(posedge clk);
        while (!req_ready)
        begin
            @(posedge clk);
        end
        if (r.action == ACT_ADD)
        begin
            known_routes.insert(known_routes.size(), r);
            if (known_routes.size() > 96)
            begin
                void'(known_routes.pop_front());
            end
        end
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
        begin
            gap++;
        end
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic put(logic [2:0] action, logic [31:0] addr, logic [5:0] length,
                       logic [3:0] intf, logic state);
        send_beat('{action: action, addr: addr, length: length,
                    intf_index: intf, intf_state: state});
    endtask

    function automatic logic [5:0] random_length();
        int pick;
        pick = $urandom_range(99);
        if (pick < 8)
        begin
            return 6'd0;
        end
        else if (pick < 18)
        begin
            return 6'($urandom_range(33, 63));
        end
        return 6'($urandom_range(1, 32));
    endfunction

    // Mostly well-formed traffic: lookups aimed at stored prefixes, adds under a few
    // shared bases so prefixes nest, and removes of routes that were added.
    function automatic req_t make_random_req();
        req_t        r;
        req_t        known;
        int          pick;
        int          eff;
        logic [31:0] m;
        logic [31:0] bases [4];
        bases = '{32'h0A00_0000, 32'hC0A8_0000, 32'hAC10_0000, 32'hFFFF_0000};
        r.addr = $urandom();
        r.length = random_length();
        r.intf_index = 4'($urandom_range(15));
        r.intf_state = 1'($urandom_range(1));
        pick = $urandom_range(99);
        if (pick < 45)
        begin
            r.action = ACT_LOOKUP;
            if (known_routes.size() > 0 && $urandom_range(99) < 75)
            begin
                known = known_routes[$urandom_range(known_routes.size() - 1)];
                eff = (known.length > ADDR_BITS) ? ADDR_BITS : known.length;
                m = ADDR_ALL_ONES << (ADDR_BITS - eff);
                r.addr = (known.addr & m) | ($urandom() & ~m);
            end
        end
        else if (pick < 70)
        begin
            r.action = ACT_ADD;
            if ($urandom_range(99) < 70)
            begin
                r.addr = bases[$urandom_range(3)] | 32'($urandom_range(16'hFFFF));
            end
        end
        else if (pick < 78)
        begin
            r.action = ACT_REMOVE;
            if (known_routes.size() > 0 && $urandom_range(99) < 70)
            begin
                known = known_routes[$urandom_range(known_routes.size() - 1)];
                r.addr = known.addr;
                r.length = known.length;
            end
        end
        else if (pick < 93)
        begin
            r.action = ACT_SET_STATE;
            r.intf_state = ($urandom_range(99) < 75);
        end
        else if (pick < 96)
        begin
            r.action = ACT_DROP;
        end
        else
        begin
            r.action = ACT_DROP + 3'($urandom_range(1, 3));
        end
        return r;
    endfunction

    task automatic run_phase(int beats, int idle_pct, int stall_pct, logic hold);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        hold_req <= hold;
        repeat (beats)
        begin
            send_beat(make_random_req());
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        put(ACT_LOOKUP,    32'hFFFF_FFFF, 6'd0,  4'd0,  1'b0);
        put(ACT_SET_STATE, 32'h0,         6'd0,  4'd0,  1'b1);
        put(ACT_SET_STATE, 32'h0,         6'd0,  4'd15, 1'b1);
        put(ACT_ADD,       32'h0,         6'd0,  4'd0,  1'b0);
        put(ACT_ADD,       32'hFFFF_FFFF, 6'd32, 4'd15, 1'b1);
        put(ACT_ADD,       32'h0A00_0000, 6'd8,  4'd1,  1'b0);
        put(ACT_LOOKUP,    32'h0A01_0203, 6'd0,  4'd0,  1'b0);
        put(ACT_SET_STATE, 32'h0,         6'd0,  4'd1,  1'b1);
        put(ACT_LOOKUP,    32'h0A01_0203, 6'd0,  4'd0,  1'b0);
        put(ACT_ADD,       32'h0A00_0000, 6'd8,  4'd2,  1'b0);
        put(ACT_SET_STATE, 32'h0,         6'd0,  4'd2,  1'b1);
        put(ACT_LOOKUP,    32'h0A01_0203, 6'd0,  4'd0,  1'b0);
        put(ACT_ADD,       32'h0A0B_0C0D, 6'd16, 4'd0,  1'b0);
        put(ACT_LOOKUP,    32'h0A0B_FFFF, 6'd0,  4'd0,  1'b0);
        put(ACT_REMOVE,    32'h0A0B_0000, 6'd16, 4'd0,  1'b0);
        put(ACT_REMOVE,    32'h0A0B_0C0D, 6'd16, 4'd0,  1'b0);
        put(ACT_ADD,       32'h1234_5678, 6'd40, 4'd15, 1'b0);
        put(ACT_LOOKUP,    32'h1234_5678, 6'd0,  4'd0,  1'b0);
        put(ACT_LOOKUP,    32'hFFFF_FFFF, 6'd63, 4'd15, 1'b1);
        put(ACT_SET_STATE, 32'h0,         6'd0,  4'd15, 1'b0);
        put(ACT_LOOKUP,    32'hFFFF_FFFF, 6'd0,  4'd0,  1'b0);
        put(ACT_DROP,      32'h0,         6'd0,  4'd1,  1'b0);
        put(ACT_LOOKUP,    32'h0A01_0203, 6'd0,  4'd0,  1'b0);
        put(3'($urandom_range(5, 7)), 32'hFFFF_FFFF, 6'd63, 4'd15, 1'b1);
        put(ACT_REMOVE,    32'h1234_5678, 6'd40, 4'd0,  1'b0);

        run_phase(400, 0, 0, 1'b0);
        run_phase(400, 63, 0, 1'b0);
        run_phase(400, 0, 63, 1'b0);
        run_phase(400, 35, 35, 1'b0);
        run_phase(350, 0, 0, 1'b1);

        req_valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (pending_count != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && pending_count == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/lrt_pkg.sv
design/lrt_ram.sv
design/lpm_route_table_unit.sv
sim/lpm_route_table_checker.sv
sim/tb_lpm_route_table_unit.sv
